// File: rtl/cfe_pkg.sv
// shared types and constants of the convolution engine
package cfe_pkg;

	localparam int MAX_IN_CH  = 16;
	localparam int MAX_OUT_CH = 16;
	localparam int MAX_KERNEL = 7;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_WIDTH  = 64;

	localparam int TAPS         = MAX_KERNEL * MAX_KERNEL;
	localparam int SAMPLE_DEPTH = MAX_IN_CH * MAX_HEIGHT * MAX_WIDTH;
	localparam int WEIGHT_DEPTH = MAX_OUT_CH * MAX_IN_CH * TAPS;
	localparam int SAW          = $clog2(SAMPLE_DEPTH);
	localparam int WAW          = $clog2(WEIGHT_DEPTH);
	localparam int QDEPTH       = 4;
	localparam int QAW          = $clog2(QDEPTH);

	localparam int ACC_W = 48;

	localparam logic [1:0] OP_WEIGHT  = 2'd0;
	localparam logic [1:0] OP_BIAS    = 2'd1;
	localparam logic [1:0] OP_SAMPLE  = 2'd2;
	localparam logic [1:0] OP_COMPUTE = 2'd3;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	localparam logic [2:0] REG_IN_CH  = 3'd0;
	localparam logic [2:0] REG_OUT_CH = 3'd1;
	localparam logic [2:0] REG_KSIZE  = 3'd2;
	localparam logic [2:0] REG_STRIDE = 3'd3;
	localparam logic [2:0] REG_PAD    = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;
	localparam logic [2:0] REG_WIDTH  = 3'd6;

	typedef struct packed {
		logic [4:0] num_in_ch;
		logic [4:0] num_out_ch;
		logic [2:0] ksize;
		logic [2:0] stride;
		logic [1:0] padding;
		logic [6:0] in_height;
		logic [6:0] in_width;
	} cfg_t;

	// item handed from the front to the back part
	typedef struct packed {
		logic [1:0]  op;
		logic        bad;
		logic [3:0]  oc;
		logic [3:0]  ic;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] data;
	} job_t;

	typedef struct packed {
		logic        we;
		logic [SAW-1:0] addr;
		logic [15:0] data;
	} swr_t;

	typedef struct packed {
		logic        we;
		logic [WAW-1:0] addr;
		logic [15:0] data;
	} wwr_t;

endpackage

// File: rtl/cfe_front.sv
// front part: config registers, load decode, geometry check, job queue
module cfe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            operation,
	input  logic [3:0]            out_channel,
	input  logic [3:0]            in_channel,
	input  logic [5:0]            row,
	input  logic [5:0]            col,
	input  logic signed [15:0]    value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [6:0]            cfg_data,
	output cfe_pkg::cfg_t         cfg,
	output cfe_pkg::swr_t         swr,
	output cfe_pkg::wwr_t         wwr,
	output logic [15:0]           bias_tab [cfe_pkg::MAX_OUT_CH],
	output logic                  job_valid,
	output cfe_pkg::job_t         job,
	input  logic                  job_pop,
	output logic                  pending
);
	import cfe_pkg::*;

	cfg_t   cfg_q;
	logic [15:0] bias_q [MAX_OUT_CH];
	job_t   q_mem [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic   accept, push;
	logic   geom_ok, coord_ok;
	logic [8:0] span_h, span_w;
	logic [6:0] out_h, out_w;
	logic [8:0] dh, dw;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;
	assign bias_tab = bias_q;
	assign busy = (cnt_q == (QAW+1)'(QDEPTH));
	assign accept = start && !busy;
	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{num_in_ch: 5'd1, num_out_ch: 5'd1, ksize: 3'd3,
				stride: 3'd1, padding: 2'd0, in_height: 7'd64, in_width: 7'd64};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IN_CH:  cfg_q.num_in_ch  <= cfg_data[4:0];
				REG_OUT_CH: cfg_q.num_out_ch <= cfg_data[4:0];
				REG_KSIZE:  cfg_q.ksize      <= cfg_data[2:0];
				REG_STRIDE: cfg_q.stride     <= cfg_data[2:0];
				REG_PAD:    cfg_q.padding    <= cfg_data[1:0];
				REG_HEIGHT: cfg_q.in_height  <= cfg_data;
				REG_WIDTH:  cfg_q.in_width   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_OUT_CH; i++) bias_q[i] <= '0;
		end else if (job_pop && job.op == OP_BIAS) begin
			bias_q[job.oc] <= job.data;
		end
	end

	// store writes, in queue order
	always_comb begin
		swr.we   = job_pop && job.op == OP_SAMPLE;
		swr.addr = {job.ic, job.row, job.col};
		swr.data = job.data;
		wwr.we   = job_pop && job.op == OP_WEIGHT && job.row < 6'(MAX_KERNEL)
			&& job.col < 6'(MAX_KERNEL);
		wwr.addr = WAW'({job.oc, job.ic}) * WAW'(TAPS)
			+ WAW'(job.row[2:0]) * WAW'(MAX_KERNEL) + WAW'(job.col[2:0]);
		wwr.data = job.data;
	end

	// geometry and coordinate check
	always_comb begin
		span_h = 9'(cfg_q.in_height) + 9'({cfg_q.padding, 1'b0});
		span_w = 9'(cfg_q.in_width) + 9'({cfg_q.padding, 1'b0});
		geom_ok = cfg_q.num_in_ch >= 5'd1 && cfg_q.num_in_ch <= 5'(MAX_IN_CH)
			&& cfg_q.num_out_ch >= 5'd1 && cfg_q.num_out_ch <= 5'(MAX_OUT_CH)
			&& cfg_q.ksize >= 3'd1
			&& cfg_q.stride >= 3'd1 && cfg_q.stride <= 3'd4
			&& cfg_q.in_height >= 7'd1 && cfg_q.in_height <= 7'(MAX_HEIGHT)
			&& cfg_q.in_width >= 7'd1 && cfg_q.in_width <= 7'(MAX_WIDTH)
			&& span_h >= 9'(cfg_q.ksize) && span_w >= 9'(cfg_q.ksize);
		dh = span_h - 9'(cfg_q.ksize);
		dw = span_w - 9'(cfg_q.ksize);
		case (cfg_q.stride)
			3'd2:    begin out_h = 7'(dh >> 1); out_w = 7'(dw >> 1); end
			3'd3:    begin
				out_h = 7'((18'(dh) * 18'd171) >> 9);
				out_w = 7'((18'(dw) * 18'd171) >> 9);
			end
			3'd4:    begin out_h = 7'(dh >> 2); out_w = 7'(dw >> 2); end
			default: begin out_h = 7'(dh); out_w = 7'(dw); end
		endcase
		coord_ok = 5'(out_channel) < cfg_q.num_out_ch
			&& 7'(row) <= out_h && 7'(col) <= out_w;
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= '{op: operation, bad: !(geom_ok && coord_ok),
			oc: out_channel, ic: in_channel, row: row, col: col, data: value};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (job_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(job_pop);
		end
	end

	assign job_valid = (cnt_q != '0);
	assign job = q_mem[rp_q];
	assign pending = job_valid;

endmodule

// File: rtl/cfe_back.sv
// back part: tap sequencer, store memories, shared mac and rounding
module cfe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cfe_pkg::cfg_t     cfg,
	input  cfe_pkg::swr_t     swr,
	input  cfe_pkg::wwr_t     wwr,
	input  logic [15:0]       bias_tab [cfe_pkg::MAX_OUT_CH],
	input  logic              job_valid,
	input  cfe_pkg::job_t     job,
	output logic              job_pop,
	output logic              done,
	output logic signed [15:0] out_value,
	output logic [1:0]        status
);
	import cfe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_TAIL = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [15:0] smem [SAMPLE_DEPTH];
	logic [15:0] wmem [WEIGHT_DEPTH];
	logic [3:0]  oc_q, ch_q;
	logic [2:0]  kh_q, kw_q;
	logic [8:0]  base_h_q, base_w_q;
	logic [SAW-1:0] sa;
	logic [WAW-1:0] wa;
	logic        inb, last;
	logic signed [9:0] ih, iw;
	logic        v_s1, v_s2;
	logic        z_s1;
	logic signed [15:0] x_s1, w_s1;
	logic signed [31:0] p_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] t;
	logic signed [ACC_W-9:0] qv;

	assign ih = 10'(base_h_q) + 10'(kh_q) - 10'(cfg.padding);
	assign iw = 10'(base_w_q) + 10'(kw_q) - 10'(cfg.padding);
	assign inb = ih >= 0 && ih < 10'(cfg.in_height) && iw >= 0 && iw < 10'(cfg.in_width);
	assign sa = {ch_q, ih[5:0], iw[5:0]};
	assign wa = WAW'({oc_q, ch_q}) * WAW'(TAPS) + WAW'(kh_q) * WAW'(MAX_KERNEL)
		+ WAW'(kw_q);
	assign last = (5'(ch_q) == cfg.num_in_ch - 5'd1) && (kh_q == cfg.ksize - 3'd1)
		&& (kw_q == cfg.ksize - 3'd1);

	always_ff @(posedge clk) begin
		if (swr.we) smem[swr.addr] <= swr.data;
		if (wwr.we) wmem[wwr.addr] <= wwr.data;
		x_s1 <= smem[sa];
		w_s1 <= wmem[wa];
		p_s2 <= x_s1 * w_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			z_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_RUN);
			z_s1 <= inb;
			v_s2 <= v_s1 && z_s1;
			case (state_q)
				S_IDLE: if (job_valid && job.op == OP_COMPUTE)
					state_q <= job.bad ? S_OUT : S_RUN;
				S_RUN:  if (last) state_q <= S_TAIL;
				S_TAIL: if (!v_s1 && !v_s2) state_q <= S_OUT;
				S_OUT:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				oc_q <= job.oc;
				ch_q <= '0; kh_q <= '0; kw_q <= '0;
				base_h_q <= 9'(job.row) * 9'(cfg.stride);
				base_w_q <= 9'(job.col) * 9'(cfg.stride);
				acc_q <= ACC_W'($signed(bias_tab[job.oc])) <<< 8;
			end
			S_RUN: begin
				if (kw_q == cfg.ksize - 3'd1) begin
					kw_q <= '0;
					if (kh_q == cfg.ksize - 3'd1) begin
						kh_q <= '0;
						ch_q <= ch_q + 1'b1;
					end else kh_q <= kh_q + 1'b1;
				end else kw_q <= kw_q + 1'b1;
			end
			default: ;
		endcase
		if (v_s2) acc_q <= acc_q + ACC_W'(p_s2);
	end

	logic bad_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bad_q <= 1'b0;
		else if (job_pop && job.op == OP_COMPUTE) bad_q <= job.bad;
	end

	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign t  = acc_q + ACC_W'(128);
	assign qv = t[ACC_W-1:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			out_value <= '0;
			status <= ST_OK;
		end else begin
			done <= (state_q == S_OUT);
			if (state_q == S_OUT) begin
				if (bad_q) begin
					out_value <= '0; status <= ST_BAD;
				end else if (qv > 40'sd32767) begin
					out_value <= 16'sd32767; status <= ST_SAT;
				end else if (qv < -40'sd32768) begin
					out_value <= -16'sd32768; status <= ST_SAT;
				end else begin
					out_value <= qv[15:0]; status <= ST_OK;
				end
			end
		end
	end

endmodule

// File: rtl/conv2d_forward_engine.sv
// top level of the direct 2d convolution engine
// Every item, load or compute, enters a four-deep queue and is carried out in order, so a
// load never changes data that an earlier compute reads. A compute steps its input
// channels times kernel taps through one shared multiply-accumulate fed by one sample and
// one weight read per cycle, drains the product pipeline and rounds; done rises the cycle
// after the rounding. A compute that fails the check skips the taps and gives zero. busy
// is high only while the queue is full. Each result shows for one cycle on done.
module conv2d_forward_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [3:0]         out_channel,
	input  logic [3:0]         in_channel,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [15:0] value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	output logic               done,
	output logic signed [15:0] out_value,
	output logic [1:0]         status
);
	import cfe_pkg::*;

	cfg_t cfg;
	swr_t swr;
	wwr_t wwr;
	job_t job;
	logic [15:0] bias_tab [MAX_OUT_CH];
	logic job_valid, job_pop, pending;

	cfe_front u_front (
		.clk, .arst_n, .start, .busy, .operation, .out_channel, .in_channel,
		.row, .col, .value, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.cfg, .swr, .wwr, .bias_tab, .job_valid, .job, .job_pop, .pending
	);

	cfe_back u_back (
		.clk, .arst_n, .cfg, .swr, .wwr, .bias_tab, .job_valid, .job, .job_pop,
		.done, .out_value, .status
	);

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> pending) else $error("pop from empty queue");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_BAD |-> out_value == '0) else $error("error result not zero");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held two cycles");

endmodule
